[hdl/sfdf_pkg.sv]
// Shared types, constants and helper functions of the sensor frame decimal formatter.
package sfdf_pkg;

  // Frame geometry
  localparam int FRAME_LEN   = 50;
  localparam int SYNC_WINDOW = 5;
  localparam int NUM_READ    = 3;
  localparam int POS_W       = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] POS_SYNC  = POS_W'(SYNC_WINDOW);
  localparam logic [POS_W-1:0] OFF_LAST  = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] OFF_START = POS_W'(2);

  // Byte values
  localparam logic [7:0] SYNC_HI     = 8'hEF;
  localparam logic [7:0] SYNC_LO     = 8'hFE;
  localparam logic [7:0] SUM_SEED    = 8'(SYNC_HI + SYNC_LO);
  localparam logic [7:0] TAG_LEAD    = 8'h22;
  localparam logic [7:0] TAG_ZERO    = 8'h00;
  localparam logic [7:0] TAG_LEN     = 8'h02;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_POINT = 8'h2E;
  localparam logic [7:0] ASCII_PCT   = 8'h25;
  localparam logic [7:0] ASCII_COMMA = 8'h2C;

  // Reading slots
  localparam logic [1:0] K_TEMP = 2'd0;
  localparam logic [1:0] K_HUM  = 2'd1;
  localparam logic [1:0] K_CO2  = 2'd2;
  localparam logic [1:0] K_END  = 2'(NUM_READ);

  // Decimal digits of a 16-bit magnitude
  localparam logic [2:0] LAST_DIGIT = 3'd4;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_CSUM  = 2'd2,
    KIND_NOHDR = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_NEXT,
    B_SIGN,
    B_DIV,
    B_DIGIT,
    B_PCT,
    B_COMMA,
    B_STATUS
  } back_state_e;

  // One queued job: status kind plus the readings to print
  typedef struct packed {
    kind_e                      kind;
    logic [NUM_READ-1:0]        show;
    logic [NUM_READ-1:0][15:0]  value;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [POS_W-1:0] tag_base(input logic [1:0] k);
    case (k)
      K_TEMP:  tag_base = POS_W'(6);
      K_HUM:   tag_base = POS_W'(12);
      K_CO2:   tag_base = POS_W'(24);
      default: tag_base = POS_W'(6);
    endcase
  endfunction

  function automatic logic [7:0] tag_id(input logic [1:0] k);
    case (k)
      K_TEMP:  tag_id = 8'h01;
      K_HUM:   tag_id = 8'h03;
      K_CO2:   tag_id = 8'h06;
      default: tag_id = 8'h01;
    endcase
  endfunction

  function automatic logic [13:0] pow10(input logic [2:0] idx);
    case (idx)
      3'd0:    pow10 = 14'd10000;
      3'd1:    pow10 = 14'd1000;
      3'd2:    pow10 = 14'd100;
      3'd3:    pow10 = 14'd10;
      default: pow10 = 14'd1;
    endcase
  endfunction

endpackage

[hdl/sfdf_front.sv]
// Front end: takes response bytes, finds the frame, checks the sum and captures readings.
module sfdf_front import sfdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       first_i,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [POS_W-1:0]          pos_q, pos_d;
  logic [POS_W-1:0]          off_q, off_d;
  logic                      hdr_q, hdr_d;
  logic [7:0]                prior_q, prior_d;
  logic [7:0]                sum_q, sum_d;
  logic [NUM_READ-1:0][15:0] val_q, val_d;
  logic [NUM_READ-1:0][3:0]  flag_q, flag_d;
  logic                      done_q, done_d;
  logic                      in_fire;

  assign in_ready_o = !q_status_i.full;
  assign in_fire    = in_valid_i && in_ready_o;

  // Classify the byte and work out the next response state
  always_comb begin
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] rel;
    logic [7:0]       want;
    pos_d   = pos_q;
    off_d   = off_q;
    hdr_d   = hdr_q;
    prior_d = prior_q;
    sum_d   = sum_q;
    val_d   = val_q;
    flag_d  = flag_q;
    done_d  = done_q;
    push_o  = 1'b0;
    job_o   = '0;
    base    = '0;
    rel     = '0;
    want    = '0;
    if (in_fire) begin
      // A first byte restarts the response
      if (first_i) begin
        pos_d  = '0;
        off_d  = '0;
        hdr_d  = 1'b0;
        sum_d  = '0;
        val_d  = '0;
        flag_d = '0;
        done_d = 1'b0;
      end
      if (!done_d) begin
        if (!hdr_d) begin
          if (pos_d >= POS_W'(1) && pos_d <= POS_SYNC && prior_q == SYNC_HI &&
              rx_byte_i == SYNC_LO) begin
            hdr_d = 1'b1;
            sum_d = SUM_SEED;
            off_d = OFF_START;
          end else if (pos_d >= POS_SYNC) begin
            push_o     = 1'b1;
            job_o.kind = KIND_NOHDR;
            done_d     = 1'b1;
          end
        end else if (off_d < OFF_LAST) begin
          sum_d = sum_d + rx_byte_i;
          for (int k = 0; k < NUM_READ; k++) begin
            base = tag_base(2'(k));
            rel  = off_d - base;
            if (off_d >= base && rel < POS_W'(4)) begin
              case (rel[1:0])
                2'd0:    want = TAG_LEAD;
                2'd1:    want = TAG_ZERO;
                2'd2:    want = tag_id(2'(k));
                default: want = TAG_LEN;
              endcase
              if (rx_byte_i == want) begin
                flag_d[k][rel[1:0]] = 1'b1;
              end
            end else if (off_d >= base && rel == POS_W'(4)) begin
              val_d[k][15:8] = rx_byte_i;
            end else if (off_d >= base && rel == POS_W'(5)) begin
              val_d[k][7:0] = rx_byte_i;
            end
          end
          off_d = off_d + POS_W'(1);
        end else begin
          push_o      = 1'b1;
          job_o.kind  = (rx_byte_i == sum_d) ? KIND_DONE : KIND_CSUM;
          job_o.value = val_d;
          for (int k = 0; k < NUM_READ; k++) begin
            job_o.show[k] = (flag_d[k] == 4'hF);
          end
          done_d = 1'b1;
        end
        prior_d = rx_byte_i;
        if (pos_d != POS_MAX) begin
          pos_d = pos_d + POS_W'(1);
        end
      end
    end
  end

  // Hold the response state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      off_q   <= '0;
      hdr_q   <= 1'b0;
      prior_q <= '0;
      sum_q   <= '0;
      val_q   <= '0;
      flag_q  <= '0;
      done_q  <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      off_q   <= off_d;
      hdr_q   <= hdr_d;
      prior_q <= prior_d;
      sum_q   <= sum_d;
      val_q   <= val_d;
      flag_q  <= flag_d;
      done_q  <= done_d;
    end
  end

endmodule

[hdl/sfdf_queue.sv]
// Two-entry job queue between the front end and the formatter.
module sfdf_queue import sfdf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output job_t      job_o,
  output q_status_t status_o
);

  job_t       mem_q [QUEUE_DEPTH];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign job_o           = mem_q[rd_ptr_q];
  assign status_o.full   = (count_q == 2'(QUEUE_DEPTH));
  assign status_o.empty  = (count_q == 2'd0);

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i && !status_o.full) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i && !status_o.full) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i && !status_o.empty) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i && !status_o.full) - 2'(pop_i && !status_o.empty);
    end
  end

endmodule

[hdl/sfdf_back.sv]
// Back end: turns queued jobs into decimal text and status transactions.
module sfdf_back import sfdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  q_status_t  q_status_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] text_char_o,
  output kind_e      kind_o,
  output logic       last_o
);

  back_state_e state_q, state_d;
  job_t        job_q, job_d;
  logic [1:0]  k_q, k_d;
  logic [15:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [2:0]  idx_q, idx_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        started_q, started_d;
  logic        pt_q, pt_d;

  logic        ov_q;
  logic [7:0]  och_q;
  kind_e       okind_q;
  logic        olast_q;

  logic        emit;
  logic [7:0]  emit_ch;
  kind_e       emit_kind;
  logic        emit_last;
  logic        show_digit;
  logic        point_now;
  logic        slot_free;
  logic        go;
  logic [15:0] sel_val;

  assign slot_free  = !ov_q || out_ready_i;
  assign show_digit = (cnt_q != 4'd0) || started_q || (idx_q == LAST_DIGIT);
  assign point_now  = (idx_q == LAST_DIGIT) && (k_q != K_CO2) && !pt_q;
  assign go         = !emit || slot_free;

  // Pick the reading of the current slot
  always_comb begin
    case (k_q)
      K_TEMP:  sel_val = job_q.value[0];
      K_HUM:   sel_val = job_q.value[1];
      K_CO2:   sel_val = job_q.value[2];
      default: sel_val = '0;
    endcase
  end

  // Character or status each state offers
  always_comb begin
    emit      = 1'b0;
    emit_ch   = '0;
    emit_kind = KIND_TEXT;
    emit_last = 1'b0;
    case (state_q)
      B_SIGN: begin
        emit    = neg_q;
        emit_ch = ASCII_MINUS;
      end
      B_DIGIT: begin
        if (point_now) begin
          emit    = 1'b1;
          emit_ch = ASCII_POINT;
        end else begin
          emit    = show_digit;
          emit_ch = ASCII_ZERO + {4'd0, cnt_q};
        end
      end
      B_PCT: begin
        emit    = (k_q == K_HUM);
        emit_ch = ASCII_PCT;
      end
      B_COMMA: begin
        emit    = 1'b1;
        emit_ch = ASCII_COMMA;
      end
      B_STATUS: begin
        emit      = 1'b1;
        emit_kind = job_q.kind;
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Sequence the formatting steps
  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    k_d       = k_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    pt_d      = pt_q;
    pop_o     = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          k_d     = K_TEMP;
          state_d = (job_i.kind == KIND_DONE) ? B_NEXT : B_STATUS;
        end
      end
      B_NEXT: begin
        if (k_q == K_END) begin
          state_d = B_STATUS;
        end else if (job_q.show[k_q]) begin
          neg_d     = sel_val[15];
          mag_d     = sel_val[15] ? (16'd0 - sel_val) : sel_val;
          idx_d     = '0;
          cnt_d     = '0;
          started_d = 1'b0;
          pt_d      = 1'b0;
          state_d   = B_SIGN;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      B_SIGN: begin
        if (go) begin
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        // One subtraction of the current power of ten per cycle
        if (mag_q >= {2'b00, pow10(idx_q)}) begin
          mag_d = mag_q - {2'b00, pow10(idx_q)};
          cnt_d = cnt_q + 4'd1;
        end else begin
          state_d = B_DIGIT;
        end
      end
      B_DIGIT: begin
        if (go) begin
          if (point_now) begin
            pt_d = 1'b1;
          end else begin
            started_d = started_q || show_digit;
            cnt_d     = '0;
            if (idx_q == LAST_DIGIT) begin
              state_d = B_PCT;
            end else begin
              idx_d   = idx_q + 3'd1;
              state_d = B_DIV;
            end
          end
        end
      end
      B_PCT: begin
        if (go) begin
          state_d = B_COMMA;
        end
      end
      B_COMMA: begin
        if (go) begin
          k_d     = k_q + 2'd1;
          state_d = B_NEXT;
        end
      end
      B_STATUS: begin
        if (go) begin
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // Hold formatter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    k_q       <= k_d;
    mag_q     <= mag_d;
    neg_q     <= neg_d;
    idx_q     <= idx_d;
    cnt_q     <= cnt_d;
    started_q <= started_d;
    pt_q      <= pt_d;
  end

  // Output register: load on a free slot, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit && slot_free) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && slot_free) begin
      och_q   <= emit_ch;
      okind_q <= emit_kind;
      olast_q <= emit_last;
    end
  end

  assign out_valid_o = ov_q;
  assign text_char_o = och_q;
  assign kind_o      = okind_q;
  assign last_o      = olast_q;

endmodule

[hdl/sensor_frame_decimal_formatter.sv]
// Top level of the sensor frame decimal formatter.
//
// Input stream: one response byte per transaction on s_axis (tdata = byte,
// tuser = first, high on the opening byte of a response). s_axis_tready drops
// only while the two-entry job queue is full.
// The front end finds the EF FE header, sums the frame and captures the three
// tagged readings. At the frame's last byte (or when no header shows up) it
// queues a job for the formatter.
// Output stream: one character or status per transaction on m_axis
// (tdata = ASCII char, tuser = kind, tlast = final result of the response).
// The formatter produces one result per cycle at best; each decimal digit
// is found by repeated subtraction of its power of ten in the subtract loop.
// Status-only jobs (checksum error, no header) go from the queue pop to the
// status state and then into the output register. A stalled m_axis holds the
// output register and the formatter; the front end keeps accepting bytes until
// the queue fills.
// Reset idles the block until a byte with tuser set arrives; no clearing
// pass is needed.
module sensor_frame_decimal_formatter import sfdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       s_axis_tuser,   // [0] first
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] text_char
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast    // last
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  job_t      job_in;
  job_t      job_out;
  kind_e     kind;

  sfdf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .rx_byte_i  (s_axis_tdata),
    .first_i    (s_axis_tuser),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (job_in)
  );

  sfdf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job_in),
    .pop_i    (pop),
    .job_o    (job_out),
    .status_o (q_status)
  );

  sfdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .text_char_o (m_axis_tdata),
    .kind_o      (kind),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tuser = kind;

  // Final result of a response is exactly the status transaction
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_TEXT)))
    else $error("tlast does not match status kind");

  // Status transactions carry no character
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_TEXT) |-> (m_axis_tdata == 8'd0))
    else $error("status transaction with non-zero data");

  // Front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("job queue overflow");

  // Formatter never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("job queue underflow");

endmodule
